// ===== rtl/assert_macros.svh =====
// assertion macros of the hilbert transformer rtl
// no dependencies; included by hilbert_fir_transformer_top, the file that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside of reset
`define HFT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside of reset
`define HFT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/hft_pkg.sv =====
// constants and coefficient rom of the hilbert fir transformer
// no dependencies; used by every module of the block
package hft_pkg;

  localparam int Length      = 31;
  localparam int Delay       = (Length - 1) / 2;
  localparam int SampleWidth = 16;
  localparam int CoefWidth   = 16;
  localparam int CoefFrac    = 15;
  // sum of |coef| is below 2^17, so the sum grows by at most 18 bits
  localparam int AccGuard    = 18;

  typedef logic signed [CoefWidth-1:0] coef_t;

  // hamming windowed 2/(pi*k), q1.15, index is the tap delay
  localparam coef_t CoefRom [Length] = '{
    -16'sd111,   16'sd0, -16'sd192,  16'sd0, -16'sd440,  16'sd0,
    -16'sd922,   16'sd0, -16'sd1753, 16'sd0, -16'sd3213, 16'sd0,
    -16'sd6343,  16'sd0, -16'sd20651, 16'sd0, 16'sd20651, 16'sd0,
     16'sd6343,  16'sd0,  16'sd3213, 16'sd0,  16'sd1753, 16'sd0,
     16'sd922,   16'sd0,  16'sd440,  16'sd0,  16'sd192,  16'sd0,
     16'sd111
  };

endpackage

// ===== rtl/hft_tap_cell.sv =====
// one tap of the transposed fir chain: multiply by a fixed coefficient, add neighbor sum
// depends on hft_pkg
module hft_tap_cell #(
  parameter int            SampleWidth = hft_pkg::SampleWidth,
  parameter int            AccWidth    = hft_pkg::SampleWidth + hft_pkg::AccGuard,
  parameter hft_pkg::coef_t Coef       = '0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic signed [AccWidth-1:0]    sum_i,
  output logic signed [AccWidth-1:0]    sum_o
);

  localparam int ProdWidth = SampleWidth + hft_pkg::CoefWidth;

  logic signed [AccWidth-1:0] sum_d, sum_q;

  generate
    if (Coef == '0) begin : g_pass
      // zero tap only delays the partial sum
      assign sum_d = sum_i;
    end else begin : g_mac
      logic signed [ProdWidth-1:0] prod;
      assign prod  = ProdWidth'(sample_i) * ProdWidth'(Coef);
      assign sum_d = sum_i + AccWidth'(prod);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/hft_delay_line.sv =====
// sample delay line for the group delay output, last stage is the output register
// depends on hft_pkg
module hft_delay_line #(
  parameter int SampleWidth = hft_pkg::SampleWidth,
  parameter int Depth       = hft_pkg::Delay + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SampleWidth-1:0] sample_i,
  output logic [SampleWidth-1:0] sample_o
);

  logic [SampleWidth-1:0] stage_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        stage_q[i] <= '0;
      end
    end else if (en_i) begin
      stage_q[0] <= sample_i;
      for (int i = 1; i < Depth; i++) begin
        stage_q[i] <= stage_q[i-1];
      end
    end
  end

  assign sample_o = stage_q[Depth-1];

endmodule

// ===== rtl/hilbert_fir_transformer_top.sv =====
// Hamming windowed FIR Hilbert transformer, 31 taps in transposed form. Each request
// carries one signed Q1.15 sample and gives one result: the Hilbert output, rounded half
// up and saturated, and the input delayed by 15 samples. One request is taken every
// clock while the sink keeps up; each result appears in the cycle after its request.
// The whole tap chain advances only on a taken request, so a result held by the sink
// stalls chain and input. Reset clears the chain; outputs start from all-zero history.
// depends on hft_pkg, hft_tap_cell, hft_delay_line and assert_macros.svh
`include "assert_macros.svh"

module hilbert_fir_transformer_top #(
  parameter int SampleWidth = hft_pkg::SampleWidth
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // sample
  input  logic [((SampleWidth + 7) / 8) * 8 - 1:0]     s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // hilbert_sample, delayed_sample
  output logic [((2 * SampleWidth + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int Length   = hft_pkg::Length;
  localparam int AccWidth = SampleWidth + hft_pkg::AccGuard;
  localparam int RndWidth = AccWidth + 1;
  localparam int ShWidth  = RndWidth - hft_pkg::CoefFrac;
  localparam int OutWidth = ((2 * SampleWidth + 7) / 8) * 8;
  localparam logic signed [RndWidth-1:0] RoundBias =
    RndWidth'(longint'(1) <<< (hft_pkg::CoefFrac - 1));
  localparam logic signed [ShWidth-1:0] SatMax =
    ShWidth'((longint'(1) <<< (SampleWidth - 1)) - 1);
  localparam logic signed [ShWidth-1:0] SatMin = -SatMax - ShWidth'(1);

  logic                          accept;
  logic                          out_valid_d, out_valid_q;
  logic signed [SampleWidth-1:0] sample;
  logic signed [AccWidth-1:0]    sum_chain [Length+1];
  logic [SampleWidth-1:0]        delayed;
  logic signed [RndWidth-1:0]    rounded;
  logic signed [ShWidth-1:0]     scaled;
  logic [SampleWidth-1:0]        hilbert;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign sample          = s_axis_tdata_i[SampleWidth-1:0];

  assign sum_chain[Length] = '0;

  generate
    for (genvar k = 0; k < Length; k++) begin : g_tap
      hft_tap_cell #(
        .SampleWidth (SampleWidth),
        .AccWidth    (AccWidth),
        .Coef        (hft_pkg::CoefRom[k])
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (accept),
        .sample_i (sample),
        .sum_i    (sum_chain[k+1]),
        .sum_o    (sum_chain[k])
      );
    end
  endgenerate

  hft_delay_line #(
    .SampleWidth (SampleWidth),
    .Depth       (hft_pkg::Delay + 1)
  ) u_delay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (accept),
    .sample_i (s_axis_tdata_i[SampleWidth-1:0]),
    .sample_o (delayed)
  );

  // round half up to q1.15 and saturate
  assign rounded = RndWidth'(sum_chain[0]) + RoundBias;
  assign scaled  = ShWidth'(rounded >>> hft_pkg::CoefFrac);

  always_comb begin
    if (scaled > SatMax) begin
      hilbert = SatMax[SampleWidth-1:0];
    end else if (scaled < SatMin) begin
      hilbert = SatMin[SampleWidth-1:0];
    end else begin
      hilbert = scaled[SampleWidth-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

  generate
    if (OutWidth > 2 * SampleWidth) begin : g_pad
      assign m_axis_tdata_o = {{(OutWidth - 2 * SampleWidth){1'b0}}, delayed, hilbert};
    end else begin : g_nopad
      assign m_axis_tdata_o = {delayed, hilbert};
    end
  endgenerate

  `HFT_ASSERT(a_accept_gives_result, clk_i, rst_ni, accept |=> out_valid_q, "request lost")
  `HFT_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !s_axis_tready_o |-> (out_valid_q && !m_axis_tready_i), "input blocked without a held result")
  `HFT_ASSERT(a_chain_holds, clk_i, rst_ni, !accept |=> ($stable(sum_chain[0]) && $stable(delayed)), "tap chain moved without a request")

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the hilbert fir transformer: a short table of
// directed samples, then random bursts under four idle and stall mixes
// depends on hft_pkg and hilbert_fir_transformer_top
module testbench;

  localparam int Taps      = hft_pkg::Length;
  localparam int GroupDly  = hft_pkg::Delay;
  localparam int SampleW   = hft_pkg::SampleWidth;
  localparam int PhaseCnt  = 4;
  localparam int PhaseReqs = 95;
  localparam int IdleLimit = 1000;
  localparam int MsgCap    = 100;

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;
  localparam longint          HamAQ30 = 64'sd579820585;
  localparam longint unsigned HamBQ30 = 64'd493921239;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  typedef logic signed [SampleW-1:0] sample_t;

  // hilbert_sample in the low half, delayed_sample in the high half
  typedef struct packed {
    sample_t delayed;
    sample_t hilbert;
  } filter_out_t;

  typedef struct {
    sample_t     sample;
    bit          typed;
    filter_out_t res;
  } stim_row_t;

  typedef enum int {
    BurstUniform,
    BurstExtreme,
    BurstSmall,
    BurstAligned
  } burst_kind_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic [SampleW-1:0]   s_data = '0;
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [2*SampleW-1:0] m_data;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_cnt = 0;
  int idle_cycles = 0;

  sample_t     history [Taps];
  int          wr_pos = 0;
  sample_t     coef_tab [Taps];
  filter_out_t awaited_out [$];

  // sat check at row 18: +full scale at taps 18 and 16, -full scale at 14 and 12
  stim_row_t stim_rows [23] = '{
    '{16'sh7fff, 1'b1, '{delayed: 16'sh0000, hilbert: -16'sd111}},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh0001, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'shffff, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'sh0001, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'sh5555, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'shaaaa, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'sh7ffe, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'shfffe, 1'b0, '0},
    '{16'sh0000, 1'b1, '{delayed: 16'sh8000, hilbert: 16'sh7fff}},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh0000, 1'b0, '0},
    '{16'sh1234, 1'b0, '0}
  };

  hilbert_fir_transformer_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5 clk = ~clk;

  // cos(2*pi*num/den) in q30, angle folded to the first quadrant
  function automatic longint cos_q30(int unsigned num, int unsigned den);
    longint unsigned m, a, x, x2, term;
    longint          acc;
    bit              neg;
    if (den == 0) return longint'(OneQ30);
    neg = 1'b0;
    m = num % den;
    if (2 * m > den) m = den - m;
    a = 2 * m;
    if (4 * m > den) begin
      a = den - a;
      neg = 1'b1;
    end
    x = (2 * PiQ30 * a) / (2 * longint'(den));
    x2 = (x * x) >> 30;
    term = OneQ30;
    acc = longint'(OneQ30);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return neg ? -acc : acc;
  endfunction

  // hamming windowed 2/(pi*k) tap, zero on even distance from the center
  function automatic sample_t window_tap(int n);
    int              k, ak;
    longint          c, w;
    longint unsigned mag, prod, num, den, q;
    sample_t         q16;
    k = n - Taps / 2;
    ak = (k < 0) ? -k : k;
    if (ak % 2 == 0) return '0;
    c = cos_q30(n, Taps - 1);
    mag = (c < 0) ? -c : c;
    prod = (HamBQ30 * mag + (64'd1 << 29)) >> 30;
    w = HamAQ30 - ((c < 0) ? -longint'(prod) : longint'(prod));
    if (w <= 0) return '0;
    num = longint'(w) << 16;
    den = PiQ30 * ak;
    q = (2 * num + den) / (2 * den);
    if (q > 32767) q = 32767;
    q16 = q[SampleW-1:0];
    return (k < 0) ? -q16 : q16;
  endfunction

  function automatic filter_out_t filter_sample(sample_t s);
    longint      acc, y;
    filter_out_t r;
    history[wr_pos] = s;
    acc = 0;
    for (int k = 0; k < Taps; k++) begin
      acc += longint'(coef_tab[k]) * longint'(history[(wr_pos + Taps - k) % Taps]);
    end
    y = (acc + 16384) >>> 15;
    if (y > longint'(SampleMax)) y = longint'(SampleMax);
    if (y < longint'(SampleMin)) y = longint'(SampleMin);
    r.hilbert = y[SampleW-1:0];
    r.delayed = history[(wr_pos + Taps - GroupDly) % Taps];
    wr_pos = (wr_pos + 1) % Taps;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the request
  task automatic send_sample(input sample_t s, input bit typed, input filter_out_t typed_res);
    filter_out_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= s;
    do @(posedge clk); while (!s_ready);
    r = filter_sample(s);
    awaited_out.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    filter_out_t got, want;
    if (rst_n && m_valid && m_ready) begin
      got = m_data;
      if (awaited_out.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MsgCap) $display("%0t: unexpected result %h", $time, m_data);
      end else begin
        want = awaited_out.pop_front();
        if (got.hilbert !== want.hilbert) begin
          fail_cnt++;
          if (fail_cnt <= MsgCap)
            $display("%0t: hilbert_sample expected %0d got %0d", $time, want.hilbert,
                     got.hilbert);
        end
        if (got.delayed !== want.delayed) begin
          fail_cnt++;
          if (fail_cnt <= MsgCap)
            $display("%0t: delayed_sample expected %0d got %0d", $time, want.delayed,
                     got.delayed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: watchdog, no request moved for %0d cycles", $time, IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int          src_pct [PhaseCnt];
    int          sink_pct [PhaseCnt];
    int          sent, len, k;
    bit          pos;
    burst_kind_e kind;
    sample_t     v;
    src_pct  = '{0, 50, 0, 32};
    sink_pct = '{0, 0, 50, 32};
    for (int n = 0; n < Taps; n++) begin
      coef_tab[n] = window_tap(n);
      history[n]  = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) send_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].res);

    for (int ph = 0; ph < PhaseCnt; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      sent = 0;
      while (sent < PhaseReqs) begin
        kind = burst_kind_e'($urandom_range(3));
        len  = (kind == BurstAligned) ? Taps : $urandom_range(40, 1);
        pos  = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
          case (kind)
            BurstUniform: begin
              v = $urandom;
            end
            BurstExtreme: begin
              case ($urandom_range(4))
                0: v = SampleMax;
                1: v = SampleMin;
                2: v = '0;
                3: v = -16'sd1;
                default: v = 16'sd1;
              endcase
            end
            BurstSmall: begin
              v = $urandom_range(511) - 256;
            end
            default: begin
              // full scale, sign of each tap or its inverse, saturates at last sample
              k = Taps - 1 - i;
              if (k % 2 == 0) v = ((k > Taps / 2) == pos) ? SampleMax : SampleMin;
              else v = $urandom;
            end
          endcase
          send_sample(v, 1'b0, '0);
          sent++;
        end
      end
    end

    s_valid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hft_pkg.sv
rtl/hft_tap_cell.sv
rtl/hft_delay_line.sv
rtl/hilbert_fir_transformer_top.sv
tb/sv/testbench.sv
